/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers; they compile to nothing when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

/* sv/sctag_pkg.sv */
// ---------------------------------------------------------------------------
// sctag_pkg
// Shared types and constants for the sector cache tag controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sctag_pkg;

  // default geometry
  localparam int CACHE_ENTRIES_DEF = 64;
  localparam int SECTOR_BITS_DEF   = 32;

  // fixed field widths of the transactions
  localparam int SLOT_W   = 6;
  localparam int SECTOR_W = 32;

  // function codes
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_FLUSH = 2'd2;

  typedef struct packed {
    logic [1:0]          func;
    logic [SECTOR_W-1:0] sector_num;
  } req_t;

  typedef struct packed {
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic                fill_needed;
    logic                writeback_valid;
    logic [SECTOR_W-1:0] writeback_sector;
    logic                last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_FLUSH,
    ST_FLUSH_END
  } state_t;

  // controls broadcast to every cell
  typedef struct packed {
    logic lookup;   // capture tag compare
    logic update;   // apply read/write access
    logic wr;       // access is a write
    logic hit;      // some cell matched
    logic flush;    // flush scan active
  } cell_ctrl_t;

endpackage

/* sv/sector_cache_fifo_tags_top.sv */
// ---------------------------------------------------------------------------
// sector_cache_fifo_tags_top
// Fully associative write-back sector cache tags, FIFO replacement.
// ---------------------------------------------------------------------------
// Access: a lookup state (parallel tag compare in the cells), then an update
//   state that registers the result; a new access may be accepted in update.
// Flush: a token walks the cell row, one slot per cycle; each dirty slot is
//   strobed when the next is found, the last one after the token leaves the row.
// Reset clears valid/dirty bits, tokens and the FIFO pointer at once; tags
//   are left as they are. Results cannot be stalled by the receiver.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sector_cache_fifo_tags_top
  import sctag_pkg::*;
#(
  parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF,
  parameter int SECTOR_BITS   = SECTOR_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  req_t    req,
  output logic    result_strobe,
  output result_t result
);

  localparam int IDX_W = $clog2(CACHE_ENTRIES);

  state_t                 state;
  state_t                 state_next;
  logic                   accept;
  logic [1:0]             func;
  logic [SECTOR_BITS-1:0] sector;
  logic [IDX_W-1:0]       ptr;
  logic [IDX_W-1:0]       scan_idx;
  cell_ctrl_t             ctrl;
  logic                   inject;
  logic                   is_access;

  logic [CACHE_ENTRIES:0]   tok;
  logic [CACHE_ENTRIES-1:0] match_vec;
  logic [CACHE_ENTRIES-1:0] dirty_vec;
  logic [SECTOR_BITS-1:0]   tag_vec [CACHE_ENTRIES];

  logic                   any_hit;
  logic [IDX_W-1:0]       hit_slot;
  logic                   bus_dirty;
  logic [SECTOR_BITS-1:0] bus_tag;

  logic                   pend_valid;
  logic                   pend_valid_next;
  logic [IDX_W-1:0]       pend_slot;
  logic [IDX_W-1:0]       pend_slot_next;
  logic [SECTOR_BITS-1:0] pend_tag;
  logic [SECTOR_BITS-1:0] pend_tag_next;
  logic                   result_strobe_next;
  result_t                result_next;

  assign accept    = start && !busy;
  assign inject    = accept && (req.func == FUNC_FLUSH);
  assign is_access = func inside {FUNC_READ, FUNC_WRITE};

  // row of slot cells, flush token passed down the chain
  assign tok[0] = inject;

  for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
    sctag_cell #(
      .SECTOR_BITS(SECTOR_BITS),
      .IDX_W      (IDX_W),
      .CELL_IDX   (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .sector   (sector),
      .victim   (ptr),
      .token_in (tok[i]),
      .token_out(tok[i+1]),
      .match    (match_vec[i]),
      .rd_dirty (dirty_vec[i]),
      .rd_tag   (tag_vec[i])
    );
  end

  // combine cell outputs: at most one match, at most one cell selected
  always_comb begin
    hit_slot = '0;
    bus_tag  = '0;
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      if (match_vec[i]) begin
        hit_slot = hit_slot | IDX_W'(i);
      end
      bus_tag = bus_tag | tag_vec[i];
    end
  end
  assign any_hit   = |match_vec;
  assign bus_dirty = |dirty_vec;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE, ST_UPDATE, ST_FLUSH_END: begin
        if (accept) begin
          state_next = (req.func == FUNC_FLUSH) ? ST_FLUSH : ST_LOOKUP;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_LOOKUP: state_next = ST_UPDATE;
      ST_FLUSH: begin
        if (tok[CACHE_ENTRIES]) begin
          state_next = ST_FLUSH_END;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs and cell controls
  always_comb begin
    busy        = 1'b0;
    ctrl        = '0;
    ctrl.wr     = (func == FUNC_WRITE);
    ctrl.hit    = any_hit;
    case (state)
      ST_LOOKUP: begin
        busy        = 1'b1;
        ctrl.lookup = 1'b1;
      end
      ST_UPDATE: ctrl.update = is_access;
      ST_FLUSH: begin
        busy       = 1'b1;
        ctrl.flush = 1'b1;
      end
      default: ;
    endcase
  end

  // result and pending write-back
  always_comb begin
    result_strobe_next = 1'b0;
    result_next        = '0;
    pend_valid_next    = pend_valid;
    pend_slot_next     = pend_slot;
    pend_tag_next      = pend_tag;
    case (state)
      ST_UPDATE: begin
        result_strobe_next = 1'b1;
        result_next.last   = 1'b1;
        if (is_access) begin
          result_next.hit              = any_hit;
          result_next.slot             = SLOT_W'(any_hit ? hit_slot : ptr);
          result_next.fill_needed      = !any_hit;
          result_next.writeback_valid  = bus_dirty;
          result_next.writeback_sector = SECTOR_W'(bus_tag);
        end
      end
      ST_FLUSH: begin
        // hold each dirty slot back one find, so the final one gets last
        if (bus_dirty) begin
          if (pend_valid) begin
            result_strobe_next           = 1'b1;
            result_next.slot             = SLOT_W'(pend_slot);
            result_next.writeback_valid  = 1'b1;
            result_next.writeback_sector = SECTOR_W'(pend_tag);
          end
          pend_valid_next = 1'b1;
          pend_slot_next  = scan_idx;
          pend_tag_next   = bus_tag;
        end
      end
      ST_FLUSH_END: begin
        result_strobe_next = 1'b1;
        result_next.last   = 1'b1;
        if (pend_valid) begin
          result_next.slot             = SLOT_W'(pend_slot);
          result_next.writeback_valid  = 1'b1;
          result_next.writeback_sector = SECTOR_W'(pend_tag);
        end
        pend_valid_next = 1'b0;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ptr           <= '0;
      scan_idx      <= '0;
      pend_valid    <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      pend_valid    <= pend_valid_next;
      result_strobe <= result_strobe_next;
      // FIFO pointer advances on every miss
      if (ctrl.update && !any_hit) begin
        ptr <= (ptr == IDX_W'(CACHE_ENTRIES - 1)) ? '0 : ptr + 1'b1;
      end
      // slot index that tracks the flush token
      if (state == ST_FLUSH) begin
        scan_idx <= scan_idx + 1'b1;
      end else begin
        scan_idx <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    result    <= result_next;
    pend_slot <= pend_slot_next;
    pend_tag  <= pend_tag_next;
    if (accept) begin
      func   <= req.func;
      sector <= SECTOR_BITS'(req.sector_num);
    end
  end

  // checks
  `ASSERT_PROP(a_one_match, clk, rst, $onehot0(match_vec), "more than one tag matched")
  `ASSERT_PROP(a_one_token, clk, rst, $onehot0(tok), "more than one flush token in the row")
  `ASSERT_PROP(a_update_result, clk, rst, (state == ST_UPDATE) |=> result_strobe && result.last, "access gave no final result")
  `ASSERT_PROP(a_flush_end, clk, rst, (state == ST_FLUSH_END) |=> result_strobe && result.last && !pend_valid, "flush did not close")
  `ASSERT_NEVER(a_hit_fill, clk, rst, result_strobe && result.hit && (result.fill_needed || result.writeback_valid), "hit with fill or write-back")

endmodule

/* sv/sctag_cell.sv */
// ---------------------------------------------------------------------------
// sctag_cell
// One cache slot: tag, valid and dirty bits, compare, flush token stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sctag_cell
  import sctag_pkg::*;
#(
  parameter int SECTOR_BITS = SECTOR_BITS_DEF,
  parameter int IDX_W       = 6,
  parameter int CELL_IDX    = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cell_ctrl_t             ctrl,
  input  logic [SECTOR_BITS-1:0] sector,
  input  logic [IDX_W-1:0]       victim,
  input  logic                   token_in,
  output logic                   token_out,
  output logic                   match,
  output logic                   rd_dirty,
  output logic [SECTOR_BITS-1:0] rd_tag
);

  logic [SECTOR_BITS-1:0] tag;
  logic                   valid;
  logic                   dirty;
  logic                   token;
  logic                   is_victim;
  logic                   sel;

  assign is_victim = (victim == IDX_W'(CELL_IDX));
  assign token_out = token;

  // read-out onto the shared bus: flush scan or miss victim
  assign sel      = (ctrl.flush && token) || (ctrl.update && !ctrl.hit && is_victim);
  assign rd_dirty = sel && valid && dirty;
  assign rd_tag   = rd_dirty ? tag : '0;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      dirty <= 1'b0;
      token <= 1'b0;
      match <= 1'b0;
    end else begin
      token <= token_in;
      if (ctrl.lookup) begin
        match <= valid && (tag == sector);
      end
      if (ctrl.update) begin
        if (ctrl.hit) begin
          if (match && ctrl.wr) begin
            dirty <= 1'b1;
          end
        end else if (is_victim) begin
          valid <= 1'b1;
          dirty <= ctrl.wr;
        end
      end else if (ctrl.flush && token) begin
        dirty <= 1'b0;
      end
    end
  end

  // tag payload, written on fill
  always_ff @(posedge clk) begin
    if (ctrl.update && !ctrl.hit && is_victim) begin
      tag <= sector;
    end
  end

endmodule

/* tb/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for sector_cache_fifo_tags_top. A scoreboard class keeps
// its own copy of the tags, valid/dirty bits and FIFO pointer, predicts the
// results of every accepted transaction and checks each strobed result, field
// by field, in order. Stimulus is a directed opening (empty flush, spare code,
// sector extremes, hits, misses, flushes), then a random mix over a sector
// pool larger than the cache so that hits, fills and dirty evictions all
// occur, plus a full-cache write sweep that ends in a maximal flush.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
  import sctag_pkg::*;
();

  localparam int         N_SLOTS     = CACHE_ENTRIES_DEF;
  localparam logic [1:0] FUNC_SPARE  = 2'd3;
  localparam int         POOL_SIZE   = 80;

  // tag/policy predictor plus the queue of results it expects
  class sector_cache_scoreboard;
    logic [SECTOR_W-1:0] tags [N_SLOTS];
    bit                  valid [N_SLOTS];
    bit                  dirty [N_SLOTS];
    int unsigned         filled;
    int unsigned         victim;
    result_t             expected_q [$];
    int                  errors;

    function new();
      foreach (valid[i]) begin
        valid[i] = 1'b0;
        dirty[i] = 1'b0;
        tags[i]  = '0;
      end
      filled = 0;
      victim = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // apply one accepted transaction, queue the results it must produce
    function void note_request(req_t r);
      result_t     e;
      int          found;
      int          dirty_cnt;
      int          k;
      int unsigned s;
      e = '0;
      e.last = 1'b1;
      case (r.func)
        FUNC_FLUSH: begin
          dirty_cnt = 0;
          foreach (valid[i]) if (valid[i] && dirty[i]) dirty_cnt++;
          if (dirty_cnt == 0) expected_q.push_back(e);
          k = 0;
          foreach (valid[i]) begin
            if (valid[i] && dirty[i]) begin
              k++;
              e = '0;
              e.slot             = SLOT_W'(i);
              e.writeback_valid  = 1'b1;
              e.writeback_sector = tags[i];
              e.last             = (k == dirty_cnt);
              dirty[i]           = 1'b0;
              expected_q.push_back(e);
            end
          end
        end
        FUNC_READ, FUNC_WRITE: begin
          found = -1;
          for (int i = 0; i < N_SLOTS && found < 0; i++)
            if (valid[i] && tags[i] == r.sector_num) found = i;
          if (found >= 0) begin
            e.hit  = 1'b1;
            e.slot = SLOT_W'(found);
            if (r.func == FUNC_WRITE) dirty[found] = 1'b1;
          end else begin
            // free slot while any remain, then FIFO victim in slot order
            if (filled < N_SLOTS) begin
              s = filled;
              filled++;
            end else begin
              s = victim;
              if (valid[s] && dirty[s]) begin
                e.writeback_valid  = 1'b1;
                e.writeback_sector = tags[s];
              end
              victim = (s + 1) % N_SLOTS;
            end
            tags[s]       = r.sector_num;
            valid[s]      = 1'b1;
            dirty[s]      = (r.func == FUNC_WRITE);
            e.slot        = SLOT_W'(s);
            e.fill_needed = 1'b1;
          end
          expected_q.push_back(e);
        end
        default: expected_q.push_back(e);  // spare code: no state change
      endcase
    endfunction

    function void compare_field(string name, logic [SECTOR_W-1:0] want,
                                logic [SECTOR_W-1:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, seen);
      end
    endfunction

    // compare one strobed result with the oldest expectation
    function void check_result(result_t got);
      result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got %h", $time, got);
        return;
      end
      e = expected_q.pop_front();
      compare_field("hit", SECTOR_W'(e.hit), SECTOR_W'(got.hit));
      compare_field("slot", SECTOR_W'(e.slot), SECTOR_W'(got.slot));
      compare_field("fill_needed", SECTOR_W'(e.fill_needed), SECTOR_W'(got.fill_needed));
      compare_field("writeback_valid", SECTOR_W'(e.writeback_valid),
                    SECTOR_W'(got.writeback_valid));
      compare_field("writeback_sector", e.writeback_sector, got.writeback_sector);
      compare_field("last", SECTOR_W'(e.last), SECTOR_W'(got.last));
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  req_t    req = '0;
  logic    busy;
  logic    result_strobe;
  result_t result;

  sector_cache_scoreboard sb = new();
  logic [SECTOR_W-1:0]    sector_pool [POOL_SIZE];
  bit                     no_idle = 1'b0;

  sector_cache_fifo_tags_top dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req           (req),
    .result_strobe (result_strobe),
    .result        (result)
  );

  always #5 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (!rst && result_strobe) sb.check_result(result);
  end

  // mostly short gaps, a few long ones
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SECTOR_W-1:0] pick_sector();
    if ($urandom_range(0, 9) < 7) return sector_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // one transaction: hold start until accepted, then an optional gap
  task automatic issue(input logic [1:0] f, input logic [SECTOR_W-1:0] s);
    req_t r;
    int   gap;
    r.func       = f;
    r.sector_num = s;
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    sb.note_request(r);
    gap = no_idle ? 0 : idle_cycles();
    if (gap > 0) begin
      // junk on the request bus while start is low
      r.func       = 2'($urandom_range(0, 3));
      r.sector_num = $urandom;
      start <= 1'b0;
      req   <= r;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender holds off until every expected result is in
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic random_mix(input int count);
    int         r;
    logic [1:0] f;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 45)      f = FUNC_READ;
      else if (r < 88) f = FUNC_WRITE;
      else if (r < 96) f = FUNC_FLUSH;
      else             f = FUNC_SPARE;
      issue(f, pick_sector());
    end
  endtask

  initial begin
    foreach (sector_pool[i]) sector_pool[i] = $urandom;
    sector_pool[0] = '0;
    sector_pool[1] = '1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed opening
    issue(FUNC_FLUSH, $urandom);          // nothing dirty: empty result
    issue(FUNC_SPARE, $urandom);
    issue(FUNC_READ,  32'h0000_0000);     // miss into slot 0
    issue(FUNC_WRITE, 32'hFFFF_FFFF);     // miss, dirty
    issue(FUNC_READ,  32'h0000_0000);     // hit
    issue(FUNC_WRITE, 32'h0000_0000);     // hit marks dirty
    issue(FUNC_READ,  32'hFFFF_FFFF);
    no_idle = 1'b1;
    issue(FUNC_WRITE, 32'h8000_0000);
    issue(FUNC_READ,  32'h7FFF_FFFF);
    issue(FUNC_READ,  32'h0000_0001);
    issue(FUNC_SPARE, 32'hFFFF_FFFF);
    issue(FUNC_FLUSH, 32'h0000_0000);     // three dirty slots
    issue(FUNC_FLUSH, 32'hFFFF_FFFF);     // all clean again
    issue(FUNC_WRITE, 32'h7FFF_FFFF);
    no_idle = 1'b0;
    issue(FUNC_FLUSH, $urandom);          // single dirty slot
    issue(FUNC_WRITE, 32'h5555_5555);
    issue(FUNC_WRITE, 32'hAAAA_AAAA);
    issue(FUNC_READ,  32'h5555_5555);
    drain();

    // random traffic over the pool; fills the cache and starts evicting
    random_mix(110);
    drain();

    // write sweep of fresh sectors: every slot dirty, then a full flush
    for (int k = 0; k < N_SLOTS; k++) issue(FUNC_WRITE, $urandom);
    issue(FUNC_FLUSH, $urandom);
    random_mix(70);

    // wind down with a bound, then a tail for stray results
    start <= 1'b0;
    for (int w = 0; w < 5000 && sb.pending() > 0; w++) @(posedge clk);
    repeat (N_SLOTS + 8) @(posedge clk);
    if (sb.pending() > 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("tb_top failed");
    $finish;
  end

endmodule
